/* sv/ils_pkg.sv */
`default_nettype none

package ils_pkg;

    localparam int ILS_CAPACITY = 128;
    localparam int DATA_W       = 32;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0]               operation;
        logic [7:0]               position;
        logic signed [DATA_W-1:0] operand_value;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [6:0]               found_position;
        logic [7:0]               item_count;
        logic                     is_empty;
    } rsp_t;

endpackage

`default_nettype wire

/* sv/ils_mem.sv */
`default_nettype none

module ils_mem
    import ils_pkg::*;
#(
    parameter int DEPTH = ILS_CAPACITY,
    parameter int AW    = $clog2(ILS_CAPACITY)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ils_ctrl.sv */
`default_nettype none

module ils_ctrl
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire req_t                               req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output rsp_t                                    rsp,
    output logic                                    mem_we,
    output logic [$clog2(CAPACITY)-1:0]             mem_waddr,
    output logic [DATA_W-1:0]                       mem_wdata,
    output logic                                    mem_re,
    output logic [$clog2(CAPACITY)-1:0]             mem_raddr,
    input  wire logic [DATA_W-1:0]                  mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_FIN  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg,   state_next;
    logic [1:0]        op_reg,      op_next;
    logic [AW-1:0]     pos_reg,     pos_next;
    logic [DATA_W-1:0] val_reg,     val_next;
    logic [CW-1:0]     count_reg,   count_next;
    logic [AW-1:0]     rptr_reg,    rptr_next;
    logic [CW-1:0]     left_reg,    left_next;
    logic              rvalid_reg,  rvalid_next;
    logic [AW-1:0]     raddr_d_reg, raddr_d_next;
    logic              ok_reg,      ok_next;
    logic [DATA_W-1:0] rd_reg,      rd_next;
    logic [AW-1:0]     fpos_reg,    fpos_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg,     rsp_next;

    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     cnt_ext;
    logic [PW-1:0]     span_ext;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_p1;
    logic [AW+6:0]     fpos_wide;
    logic [CW+7:0]     cnt_wide;
    logic              last;

    assign pos_ext   = PW'(req.position);
    assign cnt_ext   = PW'(count_reg);
    assign span_ext  = cnt_ext - pos_ext;
    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_p1    = count_reg + CW'(1);
    assign fpos_wide = (AW + 7)'(fpos_reg);
    assign cnt_wide  = (CW + 8)'(count_reg);
    assign last      = (left_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        rptr_next      = rptr_reg;
        left_next      = left_reg;
        rvalid_next    = rvalid_reg;
        raddr_d_next   = raddr_d_reg;
        ok_next        = ok_reg;
        rd_next        = rd_reg;
        fpos_next      = fpos_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = rptr_reg;
        req_stall      = (state_reg != S_IDLE);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.operation;
                    pos_next    = pos_ext[AW-1:0];
                    val_next    = req.operand_value;
                    rvalid_next = 1'b0;
                    ok_next     = 1'b0;
                    rd_next     = '0;
                    fpos_next   = '0;
                    state_next  = S_DONE;
                    unique case (req.operation)
                        OP_GET:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                rptr_next  = pos_ext[AW-1:0];
                                left_next  = CW'(1);
                                state_next = S_WALK;
                            end
                        end
                        OP_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                rptr_next  = '0;
                                left_next  = count_reg;
                                state_next = S_WALK;
                            end
                        end
                        OP_INSERT:
                        begin
                            if ((count_reg < CW'(CAPACITY)) && (pos_ext <= cnt_ext))
                            begin
                                if (pos_ext == cnt_ext)
                                begin
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    rptr_next  = cnt_m1[AW-1:0];
                                    left_next  = span_ext[CW-1:0];
                                    state_next = S_WALK;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                rptr_next  = pos_ext[AW-1:0];
                                left_next  = span_ext[CW-1:0];
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // issue the next read of the walk
                if (!last)
                begin
                    mem_re       = 1'b1;
                    rptr_next    = (op_reg == OP_INSERT) ? rptr_reg - AW'(1)
                                                         : rptr_reg + AW'(1);
                    left_next    = left_reg - CW'(1);
                    rvalid_next  = 1'b1;
                    raddr_d_next = rptr_reg;
                end
                else
                begin
                    rvalid_next = 1'b0;
                end

                if (rvalid_reg)
                begin
                    unique case (op_reg)
                        OP_GET:
                        begin
                            rd_next     = mem_rdata;
                            ok_next     = 1'b1;
                            rvalid_next = 1'b0;
                            state_next  = S_DONE;
                        end
                        OP_FIND:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                ok_next     = 1'b1;
                                fpos_next   = raddr_d_reg;
                                rvalid_next = 1'b0;
                                state_next  = S_DONE;
                            end
                            else if (last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        OP_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = raddr_d_reg + AW'(1);
                            mem_wdata = mem_rdata;
                            if (last)
                            begin
                                state_next = S_FIN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (raddr_d_reg == pos_reg)
                            begin
                                rd_next = mem_rdata;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = raddr_d_reg - AW'(1);
                                mem_wdata = mem_rdata;
                            end
                            if (last)
                            begin
                                count_next = cnt_m1;
                                ok_next    = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = cnt_p1;
                ok_next    = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.ok             = ok_reg;
                    rsp_next.read_value     = rd_reg;
                    rsp_next.found_position = fpos_wide[6:0];
                    rsp_next.item_count     = cnt_wide[7:0];
                    rsp_next.is_empty       = (count_reg == '0);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            rvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            rvalid_reg    <= rvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        rptr_reg    <= rptr_next;
        raddr_d_reg <= raddr_d_next;
        ok_reg      <= ok_next;
        rd_reg      <= rd_next;
        fpos_reg    <= fpos_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* sv/indexed_list_store.sv */
// Get reads one entry; find walks from the front to a match or the end; remove walks up from
// the position, moving each entry down; insert walks down from the end, moving each entry up,
// then does the final write; an append goes straight to the final write, a rejected request
// to the result. Throughput: one request at a time, one element per cycle through the memory's
// single ports. Reset clears the count, the state and the valid flags; memory contents stay
// undefined and are never read below the count before being written, so there is no clearing pass.
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = ILS_CAPACITY
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    ils_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ils_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same entry");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while previous one in flight");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> req_stall)
        else $error("memory written while idle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> ((rsp.read_value == '0) && (rsp.found_position == '0)))
        else $error("failed result carries data");

endmodule

`default_nettype wire

/* sim/indexed_list_store_tb.sv */
`default_nettype none

module indexed_list_store_tb;
    import ils_pkg::*;

    localparam int LIST_CAP     = ILS_CAPACITY;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * LIST_CAP + 40;

    typedef struct {
        req_t beat;
        bit   hold;
    } pending_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    pending_item_t pending_reqs[$];
    rsp_t          expected_rsps[$];

    logic signed [DATA_W-1:0] model_words[LIST_CAP];
    int model_len = 0;
    int gen_len = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int stall_left = 0;

    indexed_list_store #(.CAPACITY(LIST_CAP)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic rsp_t apply_list_op(req_t beat);
        rsp_t r;
        int   p;
        bit   hit;
        r = '0;
        p = beat.position;
        hit = 1'b0;
        case (beat.operation)
            OP_GET: begin
                if (p < model_len) begin
                    r.ok = 1'b1;
                    r.read_value = model_words[p];
                end
            end
            OP_FIND: begin
                for (int i = 0; i < model_len; i++) begin
                    if (!hit && model_words[i] == beat.operand_value) begin
                        hit = 1'b1;
                        r.ok = 1'b1;
                        r.found_position = 7'(i);
                    end
                end
            end
            OP_INSERT: begin
                if (model_len < LIST_CAP && p <= model_len) begin
                    for (int i = model_len; i > p; i--)
                        model_words[i] = model_words[i-1];
                    model_words[p] = beat.operand_value;
                    model_len++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (p < model_len) begin
                    r.read_value = model_words[p];
                    for (int i = p; i + 1 < model_len; i++)
                        model_words[i] = model_words[i+1];
                    model_len--;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.item_count = 8'(model_len);
        r.is_empty = (model_len == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic queue_req(logic [1:0] op, int pos, logic [31:0] val, bit hold);
        pending_item_t item;
        item.beat.operation = op;
        item.beat.position = 8'(pos);
        item.beat.operand_value = val;
        item.hold = hold;
        pending_reqs.push_back(item);
        if (op == OP_INSERT && gen_len < LIST_CAP && pos <= gen_len)
            gen_len++;
        else if (op == OP_REMOVE && pos < gen_len)
            gen_len--;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = $urandom;
            2: v = 32'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    default: v = 32'h0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic int pick_position(logic [1:0] op);
        if (op == OP_FIND || $urandom_range(0, 99) < 15)
            return $urandom_range(0, 255);
        if (op == OP_INSERT)
            return $urandom_range(0, gen_len);
        return (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
    endfunction

    task automatic queue_random(int mode, bit hold);
        logic [1:0] op;
        int         r;
        r = $urandom_range(0, 99);
        case (mode)
            0: op = (r < 85) ? OP_INSERT : (r < 90) ? OP_FIND : (r < 95) ? OP_GET : OP_REMOVE;
            1: op = (r < 85) ? OP_REMOVE : (r < 90) ? OP_FIND : (r < 95) ? OP_GET : OP_INSERT;
            default: op = 2'($urandom_range(0, 3));
        endcase
        queue_req(op, pick_position(op), pick_value(), hold);
    endtask

    function automatic bit quiet_window();
        return ((cycle_count / 2000) % 4) == 0;
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        logic drive_valid;
        drive_valid = req_valid;
        if (rst_n) begin
            if (req_valid && !req_stall) begin
                expected_rsps.push_back(apply_list_op(req));
                drive_valid = 1'b0;
                send_gap = quiet_window() ? 0 : $urandom_range(0, 11);
            end
            if (!drive_valid) begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].hold && expected_rsps.size() > 0)) begin
                    req <= pending_reqs[0].beat;
                    drive_valid = 1'b1;
                    void'(pending_reqs.pop_front());
                end
            end
        end
        req_valid <= drive_valid;
    end

    always @(posedge clk) begin
        rsp_t want;
        logic hold_stall;
        hold_stall = 1'b0;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected beat", 32'(rsp.item_count), 32'h0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp.ok !== want.ok)
                        report_mismatch("ok", 32'(rsp.ok), 32'(want.ok));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.found_position !== want.found_position)
                        report_mismatch("found_position", 32'(rsp.found_position),
                                        32'(want.found_position));
                    if (rsp.item_count !== want.item_count)
                        report_mismatch("item_count", 32'(rsp.item_count),
                                        32'(want.item_count));
                    if (rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
                end
                stall_left = quiet_window() ? 0 : $urandom_range(0, 11);
            end
            if (stall_left > 0) begin
                stall_left--;
                hold_stall = 1'b1;
            end
        end
        rsp_stall <= hold_stall;
    end

    initial begin
        // empty list: every lookup fails
        queue_req(OP_GET, 0, 32'h0, 1'b0);
        queue_req(OP_REMOVE, 0, 32'h0, 1'b0);
        queue_req(OP_FIND, 0, 32'h0, 1'b0);
        queue_req(OP_INSERT, 1, 32'h5, 1'b0);
        // build 0, min, -1, max, -1
        queue_req(OP_INSERT, 0, 32'h8000_0000, 1'b0);
        queue_req(OP_INSERT, 1, 32'h7fff_ffff, 1'b0);
        queue_req(OP_INSERT, 1, 32'hffff_ffff, 1'b0);
        queue_req(OP_INSERT, 0, 32'h0, 1'b0);
        queue_req(OP_INSERT, 4, 32'hffff_ffff, 1'b0);
        queue_req(OP_FIND, 255, 32'hffff_ffff, 1'b0);
        queue_req(OP_FIND, 0, 32'h7fff_ffff, 1'b0);
        queue_req(OP_FIND, 128, 32'd12345, 1'b0);
        queue_req(OP_GET, 0, 32'h0, 1'b0);
        queue_req(OP_GET, 4, 32'h0, 1'b0);
        queue_req(OP_GET, 5, 32'h0, 1'b0);
        queue_req(OP_GET, 255, 32'hffff_ffff, 1'b0);
        queue_req(OP_INSERT, 6, 32'h1, 1'b0);
        queue_req(OP_REMOVE, 255, 32'h0, 1'b0);
        queue_req(OP_REMOVE, 2, 32'h0, 1'b0);
        queue_req(OP_REMOVE, 0, 32'h0, 1'b0);
        queue_req(OP_REMOVE, 2, 32'h0, 1'b1);
        queue_req(OP_REMOVE, 1, 32'h0, 1'b0);
        queue_req(OP_REMOVE, 0, 32'h0, 1'b0);
        queue_req(OP_GET, 0, 32'h0, 1'b0);

        // grow to full, mix, shrink to empty, mix
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < 180)
                queue_random(0, n == 0);
            else if (n < 260)
                queue_random(2, n == 180);
            else if (n < 420)
                queue_random(1, n == 260);
            else
                queue_random(2, n == 420);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
sv/ils_pkg.sv
sv/ils_mem.sv
sv/ils_ctrl.sv
sv/indexed_list_store.sv
sim/indexed_list_store_tb.sv
